// ===== design/kst_pkg.sv =====
// Package: constants and types shared by the keyed record slot table.
package kst_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned GRADE_W    = 4;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned ENTRY_W    = KEY_W + 2 * GRADE_W;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

endpackage

// ===== design/kst_in_if.sv =====
// Interface: request word channel of the slot table.
interface kst_in_if
  import kst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [KEY_W-1:0]    key;
  logic [GRADE_W-1:0]  grade_one;
  logic [GRADE_W-1:0]  grade_two;

  modport source (output valid, action, key, grade_one, grade_two, input ready);
  modport sink   (input valid, action, key, grade_one, grade_two, output ready);
endinterface

// ===== design/kst_out_if.sv =====
// Interface: result word channel of the slot table.
interface kst_out_if
  import kst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [SLOT_W-1:0]   slot;
  logic [GRADE_W-1:0]  found_grade_one;
  logic [GRADE_W-1:0]  found_grade_two;

  modport source (output valid, status, slot, found_grade_one, found_grade_two, input ready);
  modport sink   (input valid, status, slot, found_grade_one, found_grade_two, output ready);
endinterface

// ===== design/keyed_record_slot_table.sv =====
// Top level: keyed record slot table with a scanned key/grade memory.
//
//  channel | dir | word fields                                    | handshake
//  in_i    | in  | action, key, grade_one, grade_two              | valid/ready
//  out_o   | out | status, slot, found_grade_one, found_grade_two | valid/ready
//
// Insert and lookup scan every slot: one memory read per slot through the single read
// port into a read register, a compare of each read word, and then the response.
// Clear and the unused action skip the scan. One word is in work at a time.
// Reset drops every valid mark at once; key and grade memory needs no clearing.
// A stalled result waits in the output register; the next word is taken meanwhile.
module keyed_record_slot_table
  import kst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  kst_in_if.sink     in_i,
  kst_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e                state_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [ENTRY_W-1:0]    mem [SLOT_COUNT];
  logic [ENTRY_W-1:0]    rd_data_q;

  logic [IDX_W-1:0]      idx_q;
  logic                  issue_q;
  logic                  cmp_vld_q;
  logic                  cmp_last_q;
  logic [IDX_W-1:0]      cmp_idx_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [2*GRADE_W-1:0]  hit_grades_q;
  logic                  free_q;
  logic [IDX_W-1:0]      free_idx_q;

  action_e               act_q;
  logic [KEY_W-1:0]      key_q;
  logic [GRADE_W-1:0]    g1_q;
  logic [GRADE_W-1:0]    g2_q;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [GRADE_W-1:0]    out_g1_q;
  logic [GRADE_W-1:0]    out_g2_q;

  logic                  in_acc;
  logic                  rd_en;
  logic                  cmp_hit;
  logic                  cmp_free;
  logic                  resp_go;
  logic                  wr_en;
  status_e               res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [SLOT_W+IDX_W-1:0] res_slot_ext;
  logic [2*GRADE_W-1:0]  res_grades;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign rd_en      = (state_q == S_SCAN) && issue_q;

  assign cmp_hit  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data_q[KEY_W-1:0] == key_q);
  assign cmp_free = cmp_vld_q && !valid_q[cmp_idx_q];

  assign resp_go = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_idx    = '0;
    res_grades = '0;
    wr_en      = 1'b0;
    unique case (act_q)
      ACT_CLEAR: begin
        res_status = ST_CLEARED;
      end
      ACT_INSERT: begin
        if (hit_q) begin
          res_status = ST_DUPLICATE;
        end else if (!free_q) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_INSERTED;
          res_idx    = free_idx_q;
          wr_en      = resp_go;
        end
      end
      ACT_LOOKUP: begin
        if (hit_q) begin
          res_status = ST_FOUND;
          res_idx    = hit_idx_q;
          res_grades = hit_grades_q;
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign res_slot_ext = {{SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[free_idx_q] <= {g2_q, g1_q, key_q};
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_grades_q <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      act_q        <= ACT_NONE;
      key_q        <= '0;
      g1_q         <= '0;
      g2_q         <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NOT_FOUND;
      out_slot_q   <= '0;
      out_g1_q     <= '0;
      out_g2_q     <= '0;
    end else begin
      if (resp_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q     <= action_e'(in_i.action);
            key_q     <= in_i.key;
            g1_q      <= in_i.grade_one;
            g2_q      <= in_i.grade_two;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            idx_q     <= '0;
            cmp_vld_q <= 1'b0;
            if (in_i.action == ACT_INSERT || in_i.action == ACT_LOOKUP) begin
              issue_q <= 1'b1;
              state_q <= S_SCAN;
            end else begin
              if (in_i.action == ACT_CLEAR) begin
                valid_q <= '0;
              end
              state_q <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_q  <= rd_en;
          cmp_idx_q  <= idx_q;
          cmp_last_q <= rd_en && (idx_q == IDX_W'(SLOT_COUNT - 1));
          if (rd_en) begin
            if (idx_q == IDX_W'(SLOT_COUNT - 1)) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
          if (cmp_hit && !hit_q) begin
            hit_q        <= 1'b1;
            hit_idx_q    <= cmp_idx_q;
            hit_grades_q <= rd_data_q[ENTRY_W-1:KEY_W];
          end
          if (cmp_free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= cmp_idx_q;
          end
          if (cmp_vld_q && cmp_last_q) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_go) begin
            out_status_q <= res_status;
            out_slot_q   <= res_slot_ext[SLOT_W-1:0];
            out_g1_q     <= res_grades[GRADE_W-1:0];
            out_g2_q     <= res_grades[2*GRADE_W-1:GRADE_W];
            if (wr_en) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.slot            = out_slot_q;
  assign out_o.found_grade_one = out_g1_q;
  assign out_o.found_grade_two = out_g2_q;

endmodule

// ===== design/kst_checker.sv =====
// Checker: port-level assertions for the keyed record slot table, bound to the top.
module kst_checker
  import kst_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [2:0]         out_status_i,
  input logic [SLOT_W-1:0]  out_slot_i,
  input logic [GRADE_W-1:0] out_g1_i,
  input logic [GRADE_W-1:0] out_g2_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_slot_i) && $stable(out_g1_i) && $stable(out_g2_i))
    else $error("result word changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= ST_CLEARED)
    else $error("status code out of range");

  a_grades_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_FOUND |-> out_g1_i == '0 && out_g2_i == '0)
    else $error("grades set without a found record");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_FOUND && out_status_i != ST_INSERTED
      |-> out_slot_i == '0)
    else $error("slot set without insert or hit");

endmodule

bind keyed_record_slot_table kst_checker u_kst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_slot_i   (out_o.slot),
  .out_g1_i     (out_o.found_grade_one),
  .out_g2_i     (out_o.found_grade_two)
);
